// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the RTL of the stream cipher block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define CHA_ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define CHA_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/chacha_pkg.sv =====
// ----------------------------------------------------------------------------
// chacha_pkg
// Shared types, register indices and constants of the ChaCha stream cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package chacha_pkg;

    // Default number of rounds per keystream block
    localparam int DEF_ROUND_COUNT = 20;

    // Configuration register indices
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_THIRD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_KEY   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE      = 3'd5;

    // Quarter-round step codes (one add, xor and rotate each)
    localparam logic [1:0] STEP_FIRST  = 2'd0;
    localparam logic [1:0] STEP_SECOND = 2'd1;
    localparam logic [1:0] STEP_THIRD  = 2'd2;
    localparam logic [1:0] STEP_LAST   = 2'd3;

    // "expand 32-byte k" and "expand 16-byte k"
    localparam logic [31:0] SIGMA_WORDS [4] = '{
        32'h6170_7865, 32'h3320_646e, 32'h7962_2d32, 32'h6b20_6574
    };
    localparam logic [31:0] TAU_WORDS [4] = '{
        32'h6170_7865, 32'h3120_646e, 32'h7962_2d36, 32'h6b20_6574
    };

    // Input transaction payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_item;

    // Output transaction payload
    typedef struct packed {
        logic [7:0] result_byte;
        logic       result_last;
    } t_out_item;

    // Configuration register contents
    typedef struct packed {
        logic [63:0] key_low_word;
        logic [63:0] key_second_word;
        logic [63:0] key_third_word;
        logic [63:0] key_high_word;
        logic        long_key_mode;
        logic [63:0] nonce_value;
    } t_cfg;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_item;
        logic       load_init;
        logic       step_en;
        logic [1:0] step;
        logic       perm_fwd;
        logic       perm_back;
        logic       feed;
        logic       emit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic slot_zero;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/chacha_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// chacha_stream_cipher
// ChaCha stream cipher (58-bit block counter, 64-bit nonce), one byte per
// transaction, XORed with the keystream; encrypts and decrypts alike.
// ----------------------------------------------------------------------------
// A byte inside a 64-byte keystream block is accepted, and then the result
// register is loaded. The first byte of each block also refills the keystream
// first: the initial state is loaded, the rounds run in a datapath of four
// quarter-round lanes that each do one add, xor and rotate per cycle, and the
// feed-forward add follows. A new byte is taken only while the block is idle;
// a finished result waits in its own register. Any write to a register index
// 0 to 5 restarts the keystream at block 0; writes to other indices are
// ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chacha_stream_cipher #(
    parameter int ROUND_COUNT = chacha_pkg::DEF_ROUND_COUNT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire chacha_pkg::t_in_item             i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output chacha_pkg::t_out_item                 o_out_data,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [chacha_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]                      i_cfg_data
);
    import chacha_pkg::*;

    t_cfg       w_cfg;
    logic       w_pos_clear;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Configuration registers
    chacha_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .o_pos_clear (w_pos_clear)
    );

    // Sequencer
    chacha_ctrl #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // Working state and byte path
    chacha_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg       (w_cfg),
        .i_pos_clear (w_pos_clear),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/chacha_cfg.sv =====
// ----------------------------------------------------------------------------
// chacha_cfg
// Configuration register file: decodes writes and flags a position clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chacha_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [chacha_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]                   i_cfg_data,
    output chacha_pkg::t_cfg                   o_cfg,
    output logic                               o_pos_clear
);
    import chacha_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic n_clear;

    // Always able to take a write
    assign o_cfg_ready = 1'b1;

    // Decode the register index
    always_comb begin
        n_cfg   = r_cfg;
        n_clear = 1'b0;
        if (i_cfg_valid) begin
            n_clear = 1'b1;
            unique case (i_cfg_index)
                CFG_KEY_LOW:    n_cfg.key_low_word    = i_cfg_data;
                CFG_KEY_SECOND: n_cfg.key_second_word = i_cfg_data;
                CFG_KEY_THIRD:  n_cfg.key_third_word  = i_cfg_data;
                CFG_KEY_HIGH:   n_cfg.key_high_word   = i_cfg_data;
                CFG_LONG_KEY:   n_cfg.long_key_mode   = i_cfg_data[0];
                CFG_NONCE:      n_cfg.nonce_value     = i_cfg_data;
                default:        n_clear               = 1'b0;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{key_low_word: '0, key_second_word: '0, key_third_word: '0,
                       key_high_word: '0, long_key_mode: 1'b1, nonce_value: '0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg       = r_cfg;
    assign o_pos_clear = n_clear;

endmodule

`default_nettype wire

// ===== rtl/chacha_dp.sv =====
// ----------------------------------------------------------------------------
// chacha_dp
// Datapath: 16-word working state, four quarter-round lanes, feed-forward,
// byte position counter and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chacha_dp (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire chacha_pkg::t_dp_cmd   i_cmd,
    output chacha_pkg::t_dp_status     o_status,
    input  wire chacha_pkg::t_cfg      i_cfg,
    input  wire logic                  i_pos_clear,
    input  wire chacha_pkg::t_in_item  i_in_data,
    output chacha_pkg::t_out_item      o_out_data
);
    import chacha_pkg::*;

    logic [31:0] r_w    [16];
    logic [31:0] n_w    [16];
    logic [31:0] v_step [16];
    logic [31:0] v_init [16];
    logic [31:0] v_sum  [4];
    logic [31:0] v_mix  [4];
    logic [63:0] r_pos;
    t_in_item    r_item;
    t_out_item   r_out;
    logic [31:0] v_word;
    logic [7:0]  v_ks;

    // Rotate left by the amount of the given step
    function automatic logic [31:0] step_rotl(input logic [31:0] v, input logic [1:0] s);
        logic [31:0] r;
        case (s)
            STEP_FIRST:  r = {v[15:0], v[31:16]};
            STEP_SECOND: r = {v[19:0], v[31:20]};
            STEP_THIRD:  r = {v[23:0], v[31:24]};
            default:     r = {v[24:0], v[31:25]};
        endcase
        return r;
    endfunction

    // Build the initial block state from configuration and block number
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            v_init[i] = i_cfg.long_key_mode ? SIGMA_WORDS[i] : TAU_WORDS[i];
        end
        v_init[4]  = i_cfg.key_low_word[31:0];
        v_init[5]  = i_cfg.key_low_word[63:32];
        v_init[6]  = i_cfg.key_second_word[31:0];
        v_init[7]  = i_cfg.key_second_word[63:32];
        v_init[8]  = i_cfg.long_key_mode ? i_cfg.key_third_word[31:0]  : v_init[4];
        v_init[9]  = i_cfg.long_key_mode ? i_cfg.key_third_word[63:32] : v_init[5];
        v_init[10] = i_cfg.long_key_mode ? i_cfg.key_high_word[31:0]   : v_init[6];
        v_init[11] = i_cfg.long_key_mode ? i_cfg.key_high_word[63:32]  : v_init[7];
        v_init[12] = r_pos[37:6];
        v_init[13] = {6'd0, r_pos[63:38]};
        v_init[14] = i_cfg.nonce_value[31:0];
        v_init[15] = i_cfg.nonce_value[63:32];
    end

    // One quarter-round step in each lane; lane i works on column i
    always_comb begin
        v_step = r_w;
        for (int i = 0; i < 4; i++) begin
            if (!i_cmd.step[0]) begin
                v_sum[i]      = r_w[i] + r_w[4+i];
                v_mix[i]      = step_rotl(r_w[12+i] ^ v_sum[i], i_cmd.step);
                v_step[i]     = v_sum[i];
                v_step[12+i]  = v_mix[i];
            end else begin
                v_sum[i]      = r_w[8+i] + r_w[12+i];
                v_mix[i]      = step_rotl(r_w[4+i] ^ v_sum[i], i_cmd.step);
                v_step[8+i]   = v_sum[i];
                v_step[4+i]   = v_mix[i];
            end
        end
    end

    // Next working state: load, step with optional row rotation, feed-forward
    always_comb begin
        n_w = r_w;
        if (i_cmd.load_init) begin
            n_w = v_init;
        end else if (i_cmd.step_en) begin
            n_w = v_step;
            for (int i = 0; i < 4; i++) begin
                if (i_cmd.perm_fwd) begin
                    // line diagonals up as columns
                    n_w[4+i]  = v_step[4+((i+1)&3)];
                    n_w[8+i]  = v_step[8+((i+2)&3)];
                    n_w[12+i] = v_step[12+((i+3)&3)];
                end else if (i_cmd.perm_back) begin
                    // restore the column layout
                    n_w[4+i]  = v_step[4+((i+3)&3)];
                    n_w[8+i]  = v_step[8+((i+2)&3)];
                    n_w[12+i] = v_step[12+((i+1)&3)];
                end
            end
        end else if (i_cmd.feed) begin
            for (int k = 0; k < 16; k++) begin
                n_w[k] = r_w[k] + v_init[k];
            end
        end
    end

    // Pick the keystream byte at the current slot
    always_comb begin
        v_word = r_w[r_pos[5:2]];
        case (r_pos[1:0])
            2'd0:    v_ks = v_word[7:0];
            2'd1:    v_ks = v_word[15:8];
            2'd2:    v_ks = v_word[23:16];
            default: v_ks = v_word[31:24];
        endcase
    end

    // Hold working state, item and result
    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
        if (i_cmd.emit) begin
            r_out.result_byte <= r_item.data_byte ^ v_ks;
            r_out.result_last <= r_item.end_of_message;
        end
    end

    // Advance the byte position; clear it on a register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_pos_clear) begin
            r_pos <= '0;
        end else if (i_cmd.emit) begin
            r_pos <= r_pos + 64'd1;
        end
    end

    assign o_status.slot_zero = (r_pos[5:0] == 6'd0);
    assign o_out_data         = r_out;

endmodule

`default_nettype wire

// ===== rtl/chacha_ctrl.sv =====
// ----------------------------------------------------------------------------
// chacha_ctrl
// Controller: sequences item intake, block refill rounds and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module chacha_ctrl #(
    parameter int ROUND_COUNT = chacha_pkg::DEF_ROUND_COUNT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output chacha_pkg::t_dp_cmd        o_cmd,
    input  wire chacha_pkg::t_dp_status i_status
);
    import chacha_pkg::*;

    localparam int RND_W = $clog2(ROUND_COUNT);
    localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUND_COUNT - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FEED  = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [RND_W-1:0] r_round;
    logic [RND_W-1:0] n_round;
    logic [1:0]       r_step;
    logic [1:0]       n_step;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             v_last_step;
    logic             v_last_round;
    logic             v_diag;

    assign v_last_step  = (r_step == STEP_LAST);
    assign v_last_round = (r_round == LAST_ROUND);
    assign v_diag       = r_round[0];

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;

        // drop the result once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = i_status.slot_zero ? ST_LOAD : ST_EMIT;
                end
            end
            ST_LOAD: begin
                o_cmd.load_init = 1'b1;
                n_round = '0;
                n_step  = STEP_FIRST;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.step_en   = 1'b1;
                o_cmd.step      = r_step;
                o_cmd.perm_fwd  = v_last_step && !v_diag && !v_last_round;
                o_cmd.perm_back = v_last_step && v_diag;
                n_step = r_step + 2'd1;
                if (v_last_step) begin
                    if (v_last_round) begin
                        n_state = ST_FEED;
                    end else begin
                        n_round = r_round + RND_W'(1);
                    end
                end
            end
            ST_FEED: begin
                o_cmd.feed = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_round     <= '0;
            r_step      <= STEP_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `CHA_ASSERT_RST(a_reset_idle, i_clk,
        (!i_rst_n) |=> (r_state == ST_IDLE && !r_out_valid), "not idle after reset")
    `CHA_ASSERT_CHK(a_load_on_boundary, i_clk, i_rst_n,
        (r_state == ST_LOAD) |-> i_status.slot_zero, "refill off a block boundary")
    `CHA_ASSERT_CHK(a_feed_after_rounds, i_clk, i_rst_n,
        (r_state == ST_FEED) |->
            $past(r_state == ST_ROUND && r_step == STEP_LAST && r_round == LAST_ROUND),
        "feed-forward before rounds finished")
    `CHA_ASSERT_CHK(a_emit_waits, i_clk, i_rst_n,
        (r_state == ST_EMIT && r_out_valid && !i_out_ready) |=> (r_state == ST_EMIT),
        "result overwritten while pending")

endmodule

`default_nettype wire
